// ===== sv/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define FSP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition that must never be seen outside reset
`define FSP_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== sv/fsp_pkg.sv =====
// shared types and constants of the five stage pipeline core subset
// no dependencies
package fsp_pkg;

  typedef enum logic [2:0] {
    OP_LOAD_INSTR = 3'd0,
    OP_LOAD_DATA  = 3'd1,
    OP_TICK       = 3'd2,
    OP_READ_DATA  = 3'd3,
    OP_READ_REG   = 3'd4
  } op_e;

  localparam logic [5:0]  OPC_RTYPE = 6'h00;
  localparam logic [5:0]  OPC_LW    = 6'h23;
  localparam logic [5:0]  OPC_SW    = 6'h2B;
  localparam logic [5:0]  FN_ADDU   = 6'h21;
  localparam logic [5:0]  FN_SUBU   = 6'h23;
  localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;
  localparam logic [4:0]  REG_ZERO  = 5'b00000;

  typedef struct packed {
    logic [15:0] imm;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  dest;
    logic        imm_form;
    logic        load;
    logic        store;
    logic        add_sel;
    logic        wen;
    logic        idle;
  } ex_ctl_t;

  typedef struct packed {
    logic [4:0] dest;
    logic       load;
    logic       store;
    logic       wen;
    logic       idle;
  } mem_ctl_t;

  typedef struct packed {
    logic [4:0] dest;
    logic       wen;
    logic       idle;
  } wb_ctl_t;

  // register file write request
  typedef struct packed {
    logic        we;
    logic [4:0]  addr;
    logic [31:0] data;
  } rf_wr_t;

endpackage

// ===== sv/fsp_ram.sv =====
// single port write, single port read synchronous memory, registered read data
// no dependencies
module fsp_ram #(
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/fsp_regfile.sv =====
// 32 x 32 register file, two synchronous read ports, one write port
// depends on fsp_pkg; entries never written read as zero
module fsp_regfile
  import fsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [4:0]  ra_i,
  input  logic [4:0]  rb_i,
  input  rf_wr_t      wr_i,
  output logic [31:0] rd_a_o,
  output logic [31:0] rd_b_o
);

  logic [31:0] mem [32];
  logic [31:0] vld_q;
  logic [31:0] rd_a_q, rd_b_q;
  logic        va_q, vb_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_a_q <= mem[ra_i];
    rd_b_q <= mem[rb_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      va_q <= vld_q[ra_i];
      vb_q <= vld_q[rb_i];
    end
  end

  assign rd_a_o = va_q ? rd_a_q : '0;
  assign rd_b_o = vb_q ? rd_b_q : '0;

endmodule

// ===== sv/five_stage_pipeline_core_subset.sv =====
// five stage in-order pipeline core (addu, subu, lw, sw, bne) driven by tick items
// an item is read when accepted, then applied (update), and the result is registered
// a new item is not taken while the last one is being applied or while a result waits
//   under out_stall_i; instruction, data and register memories are read synchronously
// reset: pipeline state and register file valid bits clear at once; memories undefined
// depends on fsp_pkg, fsp_ram, fsp_regfile
module five_stage_pipeline_core_subset
  import fsp_pkg::*;
#(
  parameter int MEM_AW = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [9:0]  addr_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        halted_o,
  output logic        wb_valid_o,
  output logic [4:0]  wb_reg_o,
  output logic [31:0] wb_data_o,
  output logic        store_valid_o,
  output logic [9:0]  store_addr_o,
  output logic [31:0] stored_word_o,
  output logic [31:0] read_value_o
);

  // handshake and captured item
  logic        accept;
  logic        busy_q;
  op_e         op_q;
  logic [31:0] addr_q;
  logic [31:0] value_q;
  logic [31:0] addr_ext;

  // pipeline state
  logic [31:0] fetch_pc_q, fetch_pc_d;
  logic        fetch_idle_q, fetch_idle_d;
  logic [31:0] dec_word_q, dec_word_d;
  logic        dec_idle_q, dec_idle_d;
  logic [31:0] opa_q, opa_d, opb_q, opb_d;
  ex_ctl_t     ex_ctl_q, ex_ctl_d;
  logic [31:0] mem_result_q, mem_result_d;
  logic [31:0] mem_store_q, mem_store_d;
  mem_ctl_t    mem_ctl_q, mem_ctl_d;
  logic [31:0] wb_word_q, wb_word_d;
  wb_ctl_t     wb_ctl_q, wb_ctl_d;
  logic        halt_seen_q, halt_seen_d;

  // memory ports
  logic              im_we;
  logic [MEM_AW-1:0] im_waddr, im_raddr;
  logic [31:0]       im_rdata;
  logic              dm_we;
  logic [MEM_AW-1:0] dm_waddr, dm_raddr;
  logic [31:0]       dm_wdata, dm_rdata;
  logic [4:0]        rf_ra, rf_rb;
  logic [31:0]       rf_a, rf_b;
  rf_wr_t            rf_wr;

  // result register
  logic        out_valid_q, out_valid_d;
  logic        halted_q, halted_d;
  logic        wb_valid_q, wb_valid_d;
  logic [4:0]  wb_reg_q, wb_reg_d;
  logic [31:0] wb_data_q, wb_data_d;
  logic        st_valid_q, st_valid_d;
  logic [9:0]  st_addr_q, st_addr_d;
  logic [31:0] st_data_q, st_data_d;
  logic [31:0] rd_val_q, rd_val_d;

  // decode scratch
  logic        idle_all;
  logic        branch;
  logic [31:0] offset;
  logic [31:0] w;
  logic [31:0] rs_val, rt_val;
  logic [31:0] sext_imm;

  // write enabled, nonzero destination matching the given register
  function automatic logic rf_wr_hit(wb_ctl_t c, logic [4:0] r);
    rf_wr_hit = !c.idle && c.wen && (c.dest != REG_ZERO) && (c.dest == r);
  endfunction

  function automatic logic mem_hit(mem_ctl_t c, logic [4:0] r);
    mem_hit = !c.idle && c.wen && (c.dest != REG_ZERO) && (c.dest == r);
  endfunction

  // an item is read in the cycle it is accepted and applied in the next
  assign in_stall_o = busy_q | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;
  assign addr_ext   = {22'b0, addr_i};

  // memory read addresses come from the state as it stands at accept
  assign im_raddr = fetch_pc_q[MEM_AW+1:2];
  assign dm_raddr = (op_e'(op_i) == OP_READ_DATA) ? addr_ext[MEM_AW+1:2]
                                                  : mem_result_q[MEM_AW+1:2];
  assign rf_ra    = (op_e'(op_i) == OP_READ_REG) ? addr_i[4:0] : dec_word_q[25:21];
  assign rf_rb    = dec_word_q[20:16];

  fsp_ram #(.AW(MEM_AW), .DW(32)) u_imem (
    .clk_i   (clk_i),
    .we_i    (im_we),
    .waddr_i (im_waddr),
    .wdata_i (value_q),
    .raddr_i (im_raddr),
    .rdata_o (im_rdata)
  );

  fsp_ram #(.AW(MEM_AW), .DW(32)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .raddr_i (dm_raddr),
    .rdata_o (dm_rdata)
  );

  fsp_regfile u_rf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ra_i   (rf_ra),
    .rb_i   (rf_rb),
    .wr_i   (rf_wr),
    .rd_a_o (rf_a),
    .rd_b_o (rf_b)
  );

  assign idle_all = fetch_idle_q & dec_idle_q & ex_ctl_q.idle & mem_ctl_q.idle & wb_ctl_q.idle;
  assign im_waddr = addr_q[MEM_AW+1:2];

  always_comb begin
    fetch_pc_d   = fetch_pc_q;
    fetch_idle_d = fetch_idle_q;
    dec_word_d   = dec_word_q;
    dec_idle_d   = dec_idle_q;
    opa_d        = opa_q;
    opb_d        = opb_q;
    ex_ctl_d     = ex_ctl_q;
    mem_result_d = mem_result_q;
    mem_store_d  = mem_store_q;
    mem_ctl_d    = mem_ctl_q;
    wb_word_d    = wb_word_q;
    wb_ctl_d     = wb_ctl_q;
    halt_seen_d  = halt_seen_q;
    im_we        = 1'b0;
    dm_we        = 1'b0;
    dm_waddr     = addr_q[MEM_AW+1:2];
    dm_wdata     = value_q;
    rf_wr        = '0;
    wb_valid_d   = 1'b0;
    wb_reg_d     = '0;
    wb_data_d    = '0;
    st_valid_d   = 1'b0;
    st_addr_d    = '0;
    st_data_d    = '0;
    rd_val_d     = '0;
    branch       = 1'b0;
    offset       = '0;
    w            = dec_word_q;
    sext_imm     = {{16{dec_word_q[15]}}, dec_word_q[15:0]};
    // decode sees the register written back in the same tick
    rs_val = (rf_wr_hit(wb_ctl_q, dec_word_q[25:21])) ? wb_word_q : rf_a;
    rt_val = (rf_wr_hit(wb_ctl_q, dec_word_q[20:16])) ? wb_word_q : rf_b;

    if (busy_q) begin
      case (op_q)
        OP_LOAD_INSTR: im_we = 1'b1;
        OP_LOAD_DATA:  dm_we = 1'b1;
        OP_READ_DATA:  rd_val_d = dm_rdata;
        OP_READ_REG:   rd_val_d = rf_a;
        OP_TICK: begin
          if (!idle_all) begin
            // writeback
            if (rf_wr_hit(wb_ctl_q, wb_ctl_q.dest)) begin
              rf_wr.we   = 1'b1;
              rf_wr.addr = wb_ctl_q.dest;
              rf_wr.data = wb_word_q;
              wb_valid_d = 1'b1;
              wb_reg_d   = wb_ctl_q.dest;
              wb_data_d  = wb_word_q;
            end
            // memory stage
            wb_ctl_d.idle = mem_ctl_q.idle;
            if (!mem_ctl_q.idle) begin
              wb_ctl_d.dest = mem_ctl_q.dest;
              wb_ctl_d.wen  = mem_ctl_q.wen;
              if (mem_ctl_q.load) begin
                wb_word_d = dm_rdata;
              end else if (mem_ctl_q.store) begin
                dm_we      = 1'b1;
                dm_waddr   = mem_result_q[MEM_AW+1:2];
                dm_wdata   = mem_store_q;
                st_valid_d = 1'b1;
                st_addr_d  = mem_result_q[9:0];
                st_data_d  = mem_store_q;
              end else begin
                wb_word_d = mem_result_q;
              end
            end
            // execute stage
            mem_ctl_d.idle = ex_ctl_q.idle;
            if (!ex_ctl_q.idle) begin
              mem_ctl_d.dest  = ex_ctl_q.dest;
              mem_ctl_d.wen   = ex_ctl_q.wen;
              mem_ctl_d.store = ex_ctl_q.store;
              mem_ctl_d.load  = ex_ctl_q.load;
              mem_store_d     = opb_q;
              if (!ex_ctl_q.imm_form) begin
                mem_result_d = ex_ctl_q.add_sel ? opa_q + opb_q : opa_q - opb_q;
              end else if (ex_ctl_q.load || ex_ctl_q.store) begin
                mem_result_d = opa_q + {{16{ex_ctl_q.imm[15]}}, ex_ctl_q.imm};
              end
            end
            // decode stage, bne resolves here without forwarding from execute or memory
            ex_ctl_d.idle = dec_idle_q;
            if (!dec_idle_q) begin
              ex_ctl_d.rs       = w[25:21];
              ex_ctl_d.rt       = w[20:16];
              opa_d             = rs_val;
              opb_d             = rt_val;
              ex_ctl_d.imm_form = 1'b0;
              ex_ctl_d.load     = 1'b0;
              ex_ctl_d.store    = 1'b0;
              ex_ctl_d.imm      = w[15:0];
              if (w[31:26] == OPC_RTYPE) begin
                ex_ctl_d.dest = w[15:11];
                ex_ctl_d.wen  = 1'b1;
                // unknown funct keeps the previous add select
                if (w[5:0] == FN_ADDU) begin
                  ex_ctl_d.add_sel = 1'b1;
                end else if (w[5:0] == FN_SUBU) begin
                  ex_ctl_d.add_sel = 1'b0;
                end
              end else begin
                ex_ctl_d.imm_form = 1'b1;
                if (w[31:26] == OPC_LW) begin
                  ex_ctl_d.load = 1'b1;
                  ex_ctl_d.dest = w[20:16];
                  ex_ctl_d.wen  = 1'b1;
                end else if (w[31:26] == OPC_SW) begin
                  ex_ctl_d.store = 1'b1;
                  ex_ctl_d.wen   = 1'b0;
                end else begin
                  // bne and any unknown opcode
                  ex_ctl_d.wen = 1'b0;
                  if (rs_val != rt_val) begin
                    branch = 1'b1;
                    offset = {sext_imm[29:0], 2'b00};
                  end
                end
              end
            end
            // fetch stage
            dec_idle_d = fetch_idle_q | branch;
            if (!fetch_idle_q) begin
              dec_word_d = im_rdata;
              if (im_rdata == HALT_WORD) begin
                fetch_idle_d = 1'b1;
                dec_idle_d   = 1'b1;
                halt_seen_d  = 1'b1;
              end else begin
                fetch_pc_d = fetch_pc_q + 32'd4;
              end
              if (branch) begin
                fetch_pc_d  = fetch_pc_q + offset;
                halt_seen_d = 1'b0;
              end
            end
            // forwarding into execute: writeback first, memory stage wins
            if (rf_wr_hit(wb_ctl_d, ex_ctl_d.rs)) opa_d = wb_word_d;
            if (rf_wr_hit(wb_ctl_d, ex_ctl_d.rt)) opb_d = wb_word_d;
            if (!mem_ctl_d.load && !mem_ctl_d.store) begin
              if (mem_hit(mem_ctl_d, ex_ctl_d.rs)) opa_d = mem_result_d;
              if (mem_hit(mem_ctl_d, ex_ctl_d.rt)) opb_d = mem_result_d;
            end
            // load-use interlock: hold fetch and decode, bubble into execute
            if (mem_ctl_d.load &&
                (mem_hit(mem_ctl_d, ex_ctl_d.rs) || mem_hit(mem_ctl_d, ex_ctl_d.rt))) begin
              fetch_pc_d    = fetch_pc_q;
              fetch_idle_d  = fetch_idle_q;
              dec_word_d    = dec_word_q;
              dec_idle_d    = dec_idle_q;
              ex_ctl_d.idle = 1'b1;
            end
            if (!halt_seen_d) fetch_idle_d = 1'b0;
          end
        end
        default: ;
      endcase
    end

    halted_d = fetch_idle_d & dec_idle_d & ex_ctl_d.idle & mem_ctl_d.idle & wb_ctl_d.idle;
    out_valid_d = busy_q | (out_valid_q & out_stall_i);
  end

  // control and pipeline state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      fetch_pc_q   <= '0;
      fetch_idle_q <= 1'b0;
      dec_word_q   <= '0;
      dec_idle_q   <= 1'b1;
      opa_q        <= '0;
      opb_q        <= '0;
      ex_ctl_q     <= '{add_sel: 1'b1, idle: 1'b1, default: '0};
      mem_result_q <= '0;
      mem_store_q  <= '0;
      mem_ctl_q    <= '{idle: 1'b1, default: '0};
      wb_word_q    <= '0;
      wb_ctl_q     <= '{idle: 1'b1, default: '0};
      halt_seen_q  <= 1'b0;
    end else begin
      busy_q       <= accept;
      out_valid_q  <= out_valid_d;
      fetch_pc_q   <= fetch_pc_d;
      fetch_idle_q <= fetch_idle_d;
      dec_word_q   <= dec_word_d;
      dec_idle_q   <= dec_idle_d;
      opa_q        <= opa_d;
      opb_q        <= opb_d;
      ex_ctl_q     <= ex_ctl_d;
      mem_result_q <= mem_result_d;
      mem_store_q  <= mem_store_d;
      mem_ctl_q    <= mem_ctl_d;
      wb_word_q    <= wb_word_d;
      wb_ctl_q     <= wb_ctl_d;
      halt_seen_q  <= halt_seen_d;
    end
  end

  // captured item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(op_i);
      addr_q  <= addr_ext;
      value_q <= value_i;
    end
    if (busy_q) begin
      halted_q   <= halted_d;
      wb_valid_q <= wb_valid_d;
      wb_reg_q   <= wb_reg_d;
      wb_data_q  <= wb_data_d;
      st_valid_q <= st_valid_d;
      st_addr_q  <= st_addr_d;
      st_data_q  <= st_data_d;
      rd_val_q   <= rd_val_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign halted_o      = halted_q;
  assign wb_valid_o    = wb_valid_q;
  assign wb_reg_o      = wb_reg_q;
  assign wb_data_o     = wb_data_q;
  assign store_valid_o = st_valid_q;
  assign store_addr_o  = st_addr_q;
  assign stored_word_o = st_data_q;
  assign read_value_o  = rd_val_q;

endmodule

// ===== sv/fsp_checker.sv =====
// port level checks of the pipeline core, bound to the top level
// depends on assert_macros.svh and five_stage_pipeline_core_subset
`include "assert_macros.svh"

module fsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        wb_valid_o,
  input logic [4:0]  wb_reg_o,
  input logic        store_valid_o,
  input logic [9:0]  store_addr_o,
  input logic [31:0] stored_word_o
);

  `FSP_ASSERT(a_accept_then_busy, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)
  `FSP_ASSERT(a_accept_gives_item, clk_i, rst_ni, in_valid_i && !in_stall_o |-> ##2 out_valid_o)
  `FSP_ASSERT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)
  `FSP_NEVER(a_no_wb_zero, clk_i, rst_ni, out_valid_o && wb_valid_o && wb_reg_o == 5'd0)
  `FSP_NEVER(a_store_clear, clk_i, rst_ni, out_valid_o && !store_valid_o && (store_addr_o != 10'd0 || stored_word_o != 32'd0))

endmodule

bind five_stage_pipeline_core_subset fsp_checker u_fsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .wb_valid_o    (wb_valid_o),
  .wb_reg_o      (wb_reg_o),
  .store_valid_o (store_valid_o),
  .store_addr_o  (store_addr_o),
  .stored_word_o (stored_word_o)
);

// ===== dv/five_stage_pipeline_core_subset_tb.sv =====
// self-checking testbench of the five stage pipeline core subset: a cycle model
// of the core predicts the result of every item, a monitor compares field by field
// depends on fsp_pkg and five_stage_pipeline_core_subset
module five_stage_pipeline_core_subset_tb;
  import fsp_pkg::*;

  localparam logic [5:0] OPC_BNE = 6'h05;
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  addr;
    logic [31:0] val;
  } cmd_t;

  typedef struct packed {
    logic        halted;
    logic        wb_valid;
    logic [4:0]  wb_reg;
    logic [31:0] wb_data;
    logic        store_valid;
    logic [9:0]  store_addr;
    logic [31:0] stored_word;
    logic [31:0] read_value;
  } res_t;

  // architectural and pipeline state of the core
  typedef struct packed {
    logic [31:0] fetch_pc;
    logic        fetch_idle;
    logic [31:0] decode_word;
    logic        decode_idle;
    logic [31:0] op_a;
    logic [31:0] op_b;
    ex_ctl_t     exc;
    logic [31:0] mem_result;
    logic [31:0] mem_store_word;
    mem_ctl_t    memc;
    logic [31:0] wb_word;
    wb_ctl_t     wbc;
  } pipe_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  op_i;
  logic [9:0]  addr_i;
  logic [31:0] value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        halted_o;
  logic        wb_valid_o;
  logic [4:0]  wb_reg_o;
  logic [31:0] wb_data_o;
  logic        store_valid_o;
  logic [9:0]  store_addr_o;
  logic [31:0] stored_word_o;
  logic [31:0] read_value_o;

  five_stage_pipeline_core_subset dut (.*);

  // model state
  logic [31:0] regs_m [32];
  logic [31:0] imem_m [256];
  logic [31:0] dmem_m [256];
  pipe_t       pl;
  logic        halt_seen;

  cmd_t pending_q [$];
  res_t expected_q [$];
  int   errors = 0;
  int   cycle  = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [7:0] widx(logic [31:0] a);
    return a[9:2];
  endfunction

  function automatic logic all_idle(pipe_t p);
    return p.fetch_idle && p.decode_idle && p.exc.idle && p.memc.idle && p.wbc.idle;
  endfunction

  task automatic core_reset();
    for (int i = 0; i < 32; i++) regs_m[i] = '0;
    pl = '0;
    pl.decode_idle = 1'b1;
    pl.exc.add_sel = 1'b1;
    pl.exc.idle = 1'b1;
    pl.memc.idle = 1'b1;
    pl.wbc.idle = 1'b1;
    halt_seen = 1'b0;
  endtask

  // one pipeline clock
  task automatic core_tick(inout res_t r);
    pipe_t nx;
    logic br;
    logic [31:0] ofs, w;
    logic [5:0] opc, fn;
    if (all_idle(pl)) begin
      r.halted = 1'b1;
      return;
    end
    nx = pl;
    br = 1'b0;
    ofs = '0;
    // writeback, r0 writes dropped
    if (!pl.wbc.idle && pl.wbc.wen && pl.wbc.dest != REG_ZERO) begin
      regs_m[pl.wbc.dest] = pl.wb_word;
      r.wb_valid = 1'b1;
      r.wb_reg = pl.wbc.dest;
      r.wb_data = pl.wb_word;
    end
    // memory
    nx.wbc.idle = pl.memc.idle;
    if (!pl.memc.idle) begin
      nx.wbc.dest = pl.memc.dest;
      nx.wbc.wen = pl.memc.wen;
      if (pl.memc.load) begin
        nx.wb_word = dmem_m[widx(pl.mem_result)];
      end else if (pl.memc.store) begin
        dmem_m[widx(pl.mem_result)] = pl.mem_store_word;
        r.store_valid = 1'b1;
        r.store_addr = pl.mem_result[9:0];
        r.stored_word = pl.mem_store_word;
      end else begin
        nx.wb_word = pl.mem_result;
      end
    end
    // execute
    nx.memc.idle = pl.exc.idle;
    if (!pl.exc.idle) begin
      nx.memc.dest = pl.exc.dest;
      nx.memc.wen = pl.exc.wen;
      nx.memc.store = pl.exc.store;
      nx.memc.load = pl.exc.load;
      nx.mem_store_word = pl.op_b;
      if (!pl.exc.imm_form)
        nx.mem_result = pl.exc.add_sel ? pl.op_a + pl.op_b : pl.op_a - pl.op_b;
      else if (pl.exc.load || pl.exc.store)
        nx.mem_result = pl.op_a + sx16(pl.exc.imm);
    end
    // decode, bne compares raw register file values
    nx.exc.idle = pl.decode_idle;
    if (!pl.decode_idle) begin
      w = pl.decode_word;
      opc = w[31:26];
      fn = w[5:0];
      nx.exc.rs = w[25:21];
      nx.exc.rt = w[20:16];
      nx.op_a = regs_m[nx.exc.rs];
      nx.op_b = regs_m[nx.exc.rt];
      nx.exc.imm_form = 1'b0;
      nx.exc.load = 1'b0;
      nx.exc.store = 1'b0;
      nx.exc.imm = w[15:0];
      if (opc == OPC_RTYPE) begin
        nx.exc.dest = w[15:11];
        nx.exc.wen = 1'b1;
        // unknown funct keeps the previous add select
        if (fn == FN_ADDU) nx.exc.add_sel = 1'b1;
        else if (fn == FN_SUBU) nx.exc.add_sel = 1'b0;
      end else begin
        nx.exc.imm_form = 1'b1;
        if (opc == OPC_LW) begin
          nx.exc.load = 1'b1;
          nx.exc.dest = nx.exc.rt;
          nx.exc.wen = 1'b1;
        end else if (opc == OPC_SW) begin
          nx.exc.store = 1'b1;
          nx.exc.wen = 1'b0;
        end else begin
          // any other opcode acts as bne
          nx.exc.wen = 1'b0;
          if (nx.op_a != nx.op_b) begin
            br = 1'b1;
            ofs = sx16(nx.exc.imm) << 2;
          end
        end
      end
    end
    // fetch
    nx.decode_idle = pl.fetch_idle;
    if (br) nx.decode_idle = 1'b1;
    if (!pl.fetch_idle) begin
      w = imem_m[widx(pl.fetch_pc)];
      nx.decode_word = w;
      if (w == HALT_WORD) begin
        nx.fetch_idle = 1'b1;
        nx.decode_idle = 1'b1;
        halt_seen = 1'b1;
      end else begin
        nx.fetch_pc = pl.fetch_pc + 32'd4;
      end
      if (br) begin
        nx.fetch_pc = pl.fetch_pc + ofs;
        halt_seen = 1'b0;
      end
    end
    // forwarding, writeback first so the younger memory stage wins
    if (!nx.wbc.idle && nx.wbc.wen && nx.wbc.dest != REG_ZERO) begin
      if (nx.exc.rs == nx.wbc.dest) nx.op_a = nx.wb_word;
      if (nx.exc.rt == nx.wbc.dest) nx.op_b = nx.wb_word;
    end
    if (!nx.memc.idle && nx.memc.wen && !nx.memc.load && !nx.memc.store &&
        nx.memc.dest != REG_ZERO) begin
      if (nx.exc.rs == nx.memc.dest) nx.op_a = nx.mem_result;
      if (nx.exc.rt == nx.memc.dest) nx.op_b = nx.mem_result;
    end
    // load-use: hold fetch and decode, bubble into execute
    if (!nx.memc.idle && nx.memc.wen && nx.memc.load && nx.memc.dest != REG_ZERO &&
        (nx.memc.dest == nx.exc.rs || nx.memc.dest == nx.exc.rt)) begin
      nx.fetch_pc = pl.fetch_pc;
      nx.fetch_idle = pl.fetch_idle;
      nx.decode_word = pl.decode_word;
      nx.decode_idle = pl.decode_idle;
      nx.exc.idle = 1'b1;
    end
    if (!halt_seen) nx.fetch_idle = 1'b0;
    pl = nx;
    r.halted = all_idle(pl);
  endtask

  task automatic core_step(input cmd_t c, output res_t r);
    r = '0;
    case (c.op)
      OP_LOAD_INSTR: imem_m[widx(c.addr)] = c.val;
      OP_LOAD_DATA:  dmem_m[widx(c.addr)] = c.val;
      OP_TICK: begin
        core_tick(r);
        return;
      end
      OP_READ_DATA:  r.read_value = dmem_m[widx(c.addr)];
      OP_READ_REG:   r.read_value = regs_m[c.addr[4:0]];
      default: ;
    endcase
    r.halted = all_idle(pl);
  endtask

  // mostly a few low registers so hazards are frequent
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 5));
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [4:0] rs, rt, rd;
    logic [31:0] w;
    rs = pick_reg();
    rt = pick_reg();
    rd = pick_reg();
    case ($urandom_range(0, 9))
      0, 1:    w = {OPC_RTYPE, rs, rt, rd, 5'd0, FN_ADDU};
      2:       w = {OPC_RTYPE, rs, rt, rd, 5'd0, FN_SUBU};
      3:       w = {OPC_LW, rs, rt, 16'($urandom)};
      4:       w = {OPC_SW, rs, rt, 16'($urandom)};
      5, 6:    w = {OPC_BNE, rs, rt, 16'($urandom_range(0, 15) - 8)};
      7:       w = {OPC_RTYPE, rs, rt, rd, 11'($urandom)};
      default: w = $urandom;
    endcase
    if (w == HALT_WORD) w[0] = 1'b0;
    return w;
  endfunction

  function automatic cmd_t mk(logic [2:0] op, logic [9:0] addr, logic [31:0] val);
    cmd_t c;
    c.op = op;
    c.addr = addr;
    c.val = val;
    return c;
  endfunction

  // driver: the model is advanced on every accepted item
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    cmd_t c;
    res_t r;
    logic quiet;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i <= '0;
      addr_i <= '0;
      value_i <= '0;
    end else begin
      cycle <= cycle + 1;
      quiet = (cycle >= 1000 && cycle < 2500);
      if (in_valid_i && !in_stall_o) begin
        core_step({op_i, addr_i, value_i}, r);
        expected_q.push_back(r);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 7)) begin
          c = pending_q.pop_front();
          op_i <= c.op;
          addr_i <= c.addr;
          value_i <= c.val;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stalls at random outside the quiet stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !(cycle >= 1000 && cycle < 2500) && ($urandom_range(0, 99) < 7);
    end
  end

  function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endfunction

  // monitor: every result against the oldest prediction
  always @(posedge clk_i) begin : watch_results
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual read_value %h",
                 $time, read_value_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("halted", 32'(e.halted), 32'(halted_o));
        check_field("wb_valid", 32'(e.wb_valid), 32'(wb_valid_o));
        check_field("wb_reg", 32'(e.wb_reg), 32'(wb_reg_o));
        check_field("wb_data", e.wb_data, wb_data_o);
        check_field("store_valid", 32'(e.store_valid), 32'(store_valid_o));
        check_field("store_addr", 32'(e.store_addr), 32'(store_addr_o));
        check_field("stored_word", e.stored_word, stored_word_o);
        check_field("read_value", e.read_value, read_value_o);
      end
    end
  end

  initial begin : stimulus
    int n;
    rst_ni = 1'b0;
    core_reset();
    // every memory word written first so nothing undefined is ever read
    for (int i = 0; i < 256; i++) pending_q.push_back(mk(OP_LOAD_INSTR, 10'(i * 4), rand_instr()));
    for (int i = 0; i < 256; i++)
      pending_q.push_back(mk(OP_LOAD_DATA, 10'(i * 4 + $urandom_range(0, 3)), $urandom));
    // directed: register file after reset, unused op codes, address extremes
    pending_q.push_back(mk(OP_READ_REG, 10'd0, 32'hFFFF_FFFF));
    pending_q.push_back(mk(OP_READ_REG, 10'h3FF, 32'd0));
    pending_q.push_back(mk(OP_SPARE_5, 10'h3FF, 32'hFFFF_FFFF));
    pending_q.push_back(mk(OP_SPARE_6, 10'h155, 32'h5555_5555));
    pending_q.push_back(mk(OP_SPARE_7, 10'h2AA, 32'hAAAA_AAAA));
    pending_q.push_back(mk(OP_LOAD_DATA, 10'h3FF, 32'hFFFF_FFFF));
    pending_q.push_back(mk(OP_LOAD_DATA, 10'd0, 32'h8000_0001));
    pending_q.push_back(mk(OP_READ_DATA, 10'h3FC, 32'd0));
    // short program: load-use, forwarding, store, r0 write, branches, odd encodings
    pending_q.push_back(mk(OP_LOAD_INSTR, 10'd0, {OPC_LW, 5'd0, 5'd1, 16'd0}));
    pending_q.push_back(mk(OP_LOAD_INSTR, 10'd4, {OPC_RTYPE, 5'd1, 5'd1, 5'd2, 5'd0, FN_ADDU}));
    pending_q.push_back(mk(OP_LOAD_INSTR, 10'd8, {OPC_RTYPE, 5'd2, 5'd1, 5'd3, 5'd0, FN_SUBU}));
    pending_q.push_back(mk(OP_LOAD_INSTR, 10'd12, {OPC_SW, 5'd0, 5'd3, 16'hFFFC}));
    pending_q.push_back(mk(OP_LOAD_INSTR, 10'd16, {OPC_RTYPE, 5'd1, 5'd3, 5'd0, 5'd0, FN_ADDU}));
    pending_q.push_back(mk(OP_LOAD_INSTR, 10'd20, {OPC_RTYPE, 5'd3, 5'd1, 5'd4, 5'd0, 6'h3F}));
    pending_q.push_back(mk(OP_LOAD_INSTR, 10'd24, {OPC_BNE, 5'd1, 5'd1, 16'h7FFF}));
    pending_q.push_back(mk(OP_LOAD_INSTR, 10'd28, {6'h3E, 5'd1, 5'd0, 16'h8000}));
    for (int i = 0; i < 14; i++) pending_q.push_back(mk(OP_TICK, 10'($urandom), $urandom));
    // random part: mostly ticks with program and data rewrites in between
    for (int i = 0; i < 900; i++) begin
      n = $urandom_range(0, 99);
      if (n < 60) pending_q.push_back(mk(OP_TICK, 10'($urandom), $urandom));
      else if (n < 70) pending_q.push_back(mk(OP_LOAD_INSTR, 10'($urandom), rand_instr()));
      else if (n < 78) pending_q.push_back(mk(OP_LOAD_DATA, 10'($urandom), $urandom));
      else if (n < 86) pending_q.push_back(mk(OP_READ_DATA, 10'($urandom), $urandom));
      else if (n < 97) pending_q.push_back(mk(OP_READ_REG, 10'($urandom), $urandom));
      else pending_q.push_back(mk(3'($urandom_range(5, 7)), 10'($urandom), $urandom));
    end
    // halt word everywhere so fetch stops wherever a branch lands, then drain
    for (int i = 0; i < 256; i++) pending_q.push_back(mk(OP_LOAD_INSTR, 10'(i * 4), HALT_WORD));
    for (int i = 0; i < 20; i++) pending_q.push_back(mk(OP_TICK, 10'($urandom), $urandom));
    for (int i = 0; i < 32; i++) pending_q.push_back(mk(OP_READ_REG, 10'(i), $urandom));
    pending_q.push_back(mk(OP_READ_DATA, 10'h3FF, 32'd0));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && expected_q.size() == 0 && !in_valid_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
